// ----- sv/sot_pkg.sv -----
`default_nettype none

package sot_pkg;

    localparam int AXES     = 6;
    localparam int DATA_W   = 32;
    // Per-axis sum of up to 127 signed 32-bit samples.
    localparam int SUM_W    = 39;
    // Divisor and partial remainder width for divisors up to 127.
    localparam int DIV_W    = 7;
    // The sum magnitude is divided in a high and a low part, each by a
    // multiplication with a rounded-up reciprocal of the divisor. The
    // reciprocal shifts are chosen so that the rounding error never reaches
    // the next quotient step.
    localparam int LO_W       = 17;
    localparam int HI_W       = SUM_W - LO_W;
    localparam int DIV_K1     = HI_W + DIV_W;
    localparam int DIV_K2     = LO_W + 2 * DIV_W;
    localparam int RECIP_HI_W = DIV_K1 + 1;
    localparam int RECIP_LO_W = DIV_K2 + 1;
    localparam int DIV_STEPS  = 3;
    localparam int STEP_W     = 2;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_ABORT  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic signed [DATA_W-1:0] torque_x;
        logic signed [DATA_W-1:0] torque_y;
        logic signed [DATA_W-1:0] torque_z;
    } sample_t;

    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] out_force_x;
        logic signed [DATA_W-1:0] out_force_y;
        logic signed [DATA_W-1:0] out_force_z;
        logic signed [DATA_W-1:0] out_torque_x;
        logic signed [DATA_W-1:0] out_torque_y;
        logic signed [DATA_W-1:0] out_torque_z;
    } result_t;

    typedef struct packed {
        logic clear_sum;
        logic accumulate;
        logic div_load;
        logic div_commit;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_kind;
    } ctrl_status_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_CAL,
        ST_DIV
    } state_t;

endpackage

`default_nettype wire

// ----- sv/sot_lane.sv -----
`default_nettype none

module sot_lane #(
    parameter int CAL_SAMPLES = 100
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sot_pkg::lane_ctrl_t               ctrl,
    input  wire logic signed [sot_pkg::DATA_W-1:0] sample,
    output logic signed [sot_pkg::DATA_W-1:0]      corrected
);
    import sot_pkg::*;

    localparam logic [HI_W-1:0] DIVISOR = HI_W'(CAL_SAMPLES);
    localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_HI_W'(
        ((64'd1 << DIV_K1) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_LO_W'(
        ((64'd1 << DIV_K2) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] offset_reg, offset_next;
    logic [SUM_W-1:0]         dvd_reg, dvd_next;
    logic                     neg_reg, neg_next;
    logic [HI_W-1:0]          qhi_reg, qhi_next;
    logic [DIV_W-1:0]         rhi_reg, rhi_next;

    logic signed [DATA_W:0]           diff;
    logic [HI_W+RECIP_HI_W-1:0]       prod_hi;
    logic [HI_W-1:0]                  rem_full;
    logic [DIV_W+LO_W-1:0]            part_lo;
    logic [DIV_W+LO_W+RECIP_LO_W-1:0] prod_lo;
    logic [LO_W-1:0]                  qlo;
    logic [SUM_W-1:0]                 quot_full;
    logic [DATA_W-1:0]                quot;

    // Saturating subtraction of the stored offset.
    always_comb
    begin
        diff = {sample[DATA_W-1], sample} - {offset_reg[DATA_W-1], offset_reg};
        if (diff[DATA_W] != diff[DATA_W-1])
        begin
            corrected = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            corrected = diff[DATA_W-1:0];
        end
    end

    // Division of the sum magnitude: the high quotient part, registered, then
    // its remainder, registered, then the low quotient part from that remainder
    // and the low bits of the magnitude.
    always_comb
    begin
        prod_hi   = {{RECIP_HI_W{1'b0}}, dvd_reg[SUM_W-1:LO_W]}
                  * {{HI_W{1'b0}}, RECIP_HI};
        qhi_next  = prod_hi[DIV_K1 +: HI_W];
        rem_full  = dvd_reg[SUM_W-1:LO_W] - qhi_reg * DIVISOR;
        rhi_next  = rem_full[DIV_W-1:0];
        part_lo   = {rhi_reg, dvd_reg[LO_W-1:0]};
        prod_lo   = {{RECIP_LO_W{1'b0}}, part_lo}
                  * {{(DIV_W+LO_W){1'b0}}, RECIP_LO};
        qlo       = prod_lo[DIV_K2 +: LO_W];
        quot_full = {qhi_reg, qlo};
        // The magnitude of the mean never exceeds 2^31, so 32 bits carry it.
        quot      = quot_full[DATA_W-1:0];

        sum_next    = sum_reg;
        offset_next = offset_reg;
        dvd_next    = dvd_reg;
        neg_next    = neg_reg;

        if (ctrl.clear_sum)
        begin
            sum_next = '0;
        end
        else if (ctrl.accumulate)
        begin
            sum_next = sum_reg + SUM_W'(sample);
        end

        if (ctrl.div_load)
        begin
            neg_next = sum_reg[SUM_W-1];
            dvd_next = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
        end

        if (ctrl.div_commit)
        begin
            offset_next = neg_reg ? -quot : quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        neg_reg <= neg_next;
        qhi_reg <= qhi_next;
        rhi_reg <= rhi_next;
    end

endmodule

`default_nettype wire

// ----- sv/sot_ctrl.sv -----
`default_nettype none

module sot_ctrl #(
    parameter int CAL_SAMPLES = 100
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    req_type,
    output sot_pkg::lane_ctrl_t  lane_ctrl,
    output sot_pkg::ctrl_status_t status
);
    import sot_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        lane_ctrl  = '0;
        status     = '0;
        status.emit_kind = KIND_SAMPLE;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_SAMPLE:
                        begin
                            status.emit = 1'b1;
                        end
                        REQ_START:
                        begin
                            lane_ctrl.clear_sum = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_CAL;
                        end
                        REQ_ABORT:
                        begin
                            lane_ctrl.clear_sum = 1'b1;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CAL:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_SAMPLE:
                        begin
                            if (cnt_reg < CNT_LAST)
                            begin
                                lane_ctrl.accumulate = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                // This beat is dropped and reports completion.
                                status.emit      = 1'b1;
                                status.emit_kind = KIND_DONE;
                                lane_ctrl.div_load = 1'b1;
                                step_next  = STEP_W'(DIV_STEPS - 1);
                                state_next = ST_DIV;
                            end
                        end
                        REQ_START:
                        begin
                            lane_ctrl.clear_sum = 1'b1;
                            cnt_next = '0;
                        end
                        REQ_ABORT:
                        begin
                            lane_ctrl.clear_sum = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                status.busy = 1'b1;
                if (step_reg == '0)
                begin
                    lane_ctrl.div_commit = 1'b1;
                    lane_ctrl.clear_sum  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/six_axis_offset_tare.sv -----
// Six-axis force/torque offset tare.
// The sample channel carries one beat per request: a sensor sample, a start
// or an abort, selected by req_type. The result channel carries one beat per
// corrected sample and one completion beat per finished calibration.
// A sample outside calibration leaves as a result beat in the cycle after it
// is accepted, and samples may be accepted in every cycle without a stall.
// During calibration CAL_SAMPLES samples are accumulated and give no result;
// the next sample gives the completion beat in the following cycle. The
// offsets are then formed in each lane by two reciprocal multiplications,
// high part then low part, so the sample channel stalls after that beat
// until the offsets are formed.
// Start, abort and unused request codes give no result beat.
// Reset clears the offsets, the sums and the calibration state, and empties
// the result register.
// When the receiver stalls, the held result stays unchanged and the sample
// channel stalls with it, so no beat is lost.
`default_nettype none

module six_axis_offset_tare #(
    parameter int CAL_SAMPLES = 100
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire sot_pkg::sample_t  sample,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sot_pkg::result_t       result
);
    import sot_pkg::*;

    lane_ctrl_t   lane_ctrl;
    ctrl_status_t status;
    logic         accept;

    logic signed [DATA_W-1:0] axis_in  [AXES];
    logic signed [DATA_W-1:0] axis_out [AXES];

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    assign sample_stall = status.busy || (result_valid_reg && result_stall);
    assign accept       = sample_valid && !sample_stall;

    assign axis_in[0] = sample.force_x;
    assign axis_in[1] = sample.force_y;
    assign axis_in[2] = sample.force_z;
    assign axis_in[3] = sample.torque_x;
    assign axis_in[4] = sample.torque_y;
    assign axis_in[5] = sample.torque_z;

    sot_ctrl #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (sample.req_type),
        .lane_ctrl (lane_ctrl),
        .status    (status)
    );

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        sot_lane #(
            .CAL_SAMPLES(CAL_SAMPLES)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .sample    (axis_in[g]),
            .corrected (axis_out[g])
        );
    end

    // Merge the lanes into one result beat.
    always_comb
    begin
        result_next = result_reg;
        if (status.emit)
        begin
            result_next.result_kind = status.emit_kind;
            if (status.emit_kind == KIND_DONE)
            begin
                result_next.out_force_x  = '0;
                result_next.out_force_y  = '0;
                result_next.out_force_z  = '0;
                result_next.out_torque_x = '0;
                result_next.out_torque_y = '0;
                result_next.out_torque_z = '0;
            end
            else
            begin
                result_next.out_force_x  = axis_out[0];
                result_next.out_force_y  = axis_out[1];
                result_next.out_force_z  = axis_out[2];
                result_next.out_torque_x = axis_out[3];
                result_next.out_torque_y = axis_out[4];
                result_next.out_torque_z = axis_out[5];
            end
        end

        if (status.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- tb/six_axis_offset_tare_tb.sv -----
module six_axis_offset_tare_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sot_pkg::*;

    localparam int CAL_N       = 100;
    localparam int RANDOM_REQS = 1200;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 60;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        MIX_RANDOM,
        MIX_NEAR,
        MIX_MAX,
        MIX_MIN
    } cal_mix_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       hold;
        logic       pause;
        sample_t    beat;
    } queued_req_t;

    typedef logic [AXES-1:0][DATA_W-1:0] axis_set_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    six_axis_offset_tare #(
        .CAL_SAMPLES(CAL_N)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    queued_req_t pending_reqs[$];
    result_t     results_due[$];
    queued_req_t head_req;
    result_t     next_result;
    int          mismatches = 0;
    int          queued = 0;

    // Idle and stall chances per phase of the run, in percent.
    int          send_gap_pct [3] = '{20, 74, 0};
    int          stall_pct [3] = '{74, 20, 0};
    logic [1:0]  tx_phase = 2'd0;

    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    string       axis_names [AXES] = '{"force_x", "force_y", "force_z",
                                       "torque_x", "torque_y", "torque_z"};

    // Tare state as the block should hold it.
    logic                     cal_active;
    logic [6:0]               cal_count;
    logic signed [SUM_W-1:0]  axis_total [AXES];
    logic signed [DATA_W-1:0] axis_zero [AXES];
    logic [DATA_W-1:0]        cal_bias [AXES];

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic axis_set_t sample_axes(input sample_t s);
        return {s.torque_z, s.torque_y, s.torque_x, s.force_z, s.force_y, s.force_x};
    endfunction

    function automatic axis_set_t result_axes(input result_t r);
        return {r.out_torque_z, r.out_torque_y, r.out_torque_x,
                r.out_force_z, r.out_force_y, r.out_force_x};
    endfunction

    function automatic logic [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[DATA_W-1:0];
    endfunction

    // Advances the tare state by one accepted beat; returns 1 when a result is due.
    function automatic logic predict_tare(input sample_t s, output result_t r);
        axis_set_t ax;
        axis_set_t diff;
        int        i;
        r  = '0;
        ax = sample_axes(s);
        case (s.req_type)
            REQ_START, REQ_ABORT:
            begin
                cal_active = (s.req_type == REQ_START);
                cal_count  = '0;
                for (i = 0; i < AXES; i++)
                    axis_total[i] = '0;
                return 1'b0;
            end
            REQ_SAMPLE:
            begin
                if (cal_active)
                begin
                    if (cal_count < CAL_N)
                    begin
                        for (i = 0; i < AXES; i++)
                            axis_total[i] = axis_total[i] + $signed(ax[i]);
                        cal_count = cal_count + 7'd1;
                        return 1'b0;
                    end
                    // The beat after a full set is dropped and only reports completion.
                    for (i = 0; i < AXES; i++)
                    begin
                        axis_zero[i]  = clamp32(longint'(axis_total[i]) / CAL_N);
                        axis_total[i] = '0;
                    end
                    cal_count     = '0;
                    cal_active    = 1'b0;
                    r.result_kind = KIND_DONE;
                    return 1'b1;
                end
                for (i = 0; i < AXES; i++)
                    diff[i] = clamp32(longint'($signed(ax[i])) - longint'(axis_zero[i]));
                r = {KIND_SAMPLE, diff[0], diff[1], diff[2], diff[3], diff[4], diff[5]};
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input result_t got);
        result_t   want;
        axis_set_t g;
        axis_set_t w;
        int        i;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("result beat %h arrived with none due", got));
            return;
        end
        want = results_due.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind: got %b, expected %b",
                                      got.result_kind, want.result_kind));
        g = result_axes(got);
        w = result_axes(want);
        for (i = 0; i < AXES; i++)
            if (g[i] !== w[i])
                report_mismatch($sformatf("out_%s: got %0d, expected %0d",
                                          axis_names[i], $signed(g[i]), $signed(w[i])));
    endtask

    // Sender: the payload is only replaced once the current beat has gone.
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                if (predict_tare(sample, next_result))
                    results_due = {results_due, next_result};
            end
            if (!sample_valid || !sample_stall)
            begin
                if (pending_reqs.size() == 0
                    || $urandom_range(0, 99) < send_gap_pct[tx_phase]
                    || (pending_reqs[0].pause && results_due.size() != 0))
                    sample_valid <= 1'b0;
                else
                begin
                    head_req     = pending_reqs.pop_front();
                    sample       <= head_req.beat;
                    sample_valid <= 1'b1;
                    tx_phase     <= head_req.phase;
                    if (head_req.hold)
                        hold_asked <= hold_asked + 1;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when the sender asks for one.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (hold_left != 0)
            begin
                result_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else if (hold_asked != hold_served)
            begin
                result_stall <= 1'b1;
                hold_left    <= HOLD_CYCLES - 1;
                hold_served  <= hold_served + 1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct[tx_phase]);
        end
    end

    function automatic logic [DATA_W-1:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t make_beat(input logic [1:0] req,
                                          input logic [DATA_W-1:0] fx, fy, fz,
                                          input logic [DATA_W-1:0] tx, ty, tz);
        return {req, fx, fy, fz, tx, ty, tz};
    endfunction

    task automatic add_req(input sample_t b);
        queued_req_t q;
        q.beat  = b;
        q.phase = (queued < 500) ? 2'd0 : (queued < 1000) ? 2'd1 : 2'd2;
        q.pause = (queued == 500 || queued == 1000);
        q.hold  = (queued == 250 || queued == 1100);
        pending_reqs = {pending_reqs, q};
        queued++;
    endtask

    task automatic add_uniform(input logic [DATA_W-1:0] v);
        add_req(make_beat(REQ_SAMPLE, v, v, v, v, v, v));
    endtask

    task automatic add_rand_sample();
        add_req(make_beat(REQ_SAMPLE, rand_axis(), rand_axis(), rand_axis(),
                          rand_axis(), rand_axis(), rand_axis()));
    endtask

    task automatic add_cmd(input logic [1:0] req);
        add_req(make_beat(req, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    // A start beat followed by a number of samples, with the odd unused code mixed in.
    task automatic add_calibration(input cal_mix_t mix, input int count);
        int k;
        int i;
        for (i = 0; i < AXES; i++)
            cal_bias[i] = $urandom;
        add_cmd(REQ_START);
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 49) == 0)
                add_cmd(REQ_UNUSED);
            case (mix)
                MIX_MAX:
                    add_uniform(32'h7fff_ffff);
                MIX_MIN:
                    add_uniform(32'h8000_0000);
                MIX_NEAR:
                    add_req(make_beat(REQ_SAMPLE,
                                      cal_bias[0] + $urandom_range(0, 4000) - 2000,
                                      cal_bias[1] + $urandom_range(0, 4000) - 2000,
                                      cal_bias[2] + $urandom_range(0, 4000) - 2000,
                                      cal_bias[3] + $urandom_range(0, 4000) - 2000,
                                      cal_bias[4] + $urandom_range(0, 4000) - 2000,
                                      cal_bias[5] + $urandom_range(0, 4000) - 2000));
                default:
                    add_rand_sample();
            endcase
        end
    endtask

    initial
    begin
        int i;
        int n;
        int pick;

        cal_active = 1'b0;
        cal_count  = '0;
        for (i = 0; i < AXES; i++)
        begin
            axis_total[i] = '0;
            axis_zero[i]  = '0;
        end

        add_uniform(32'h0);
        add_uniform(32'h7fff_ffff);
        add_uniform(32'h8000_0000);
        add_req(make_beat(REQ_SAMPLE, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
        add_req(make_beat(REQ_SAMPLE, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                          32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        add_cmd(REQ_UNUSED);
        add_cmd(REQ_ABORT);
        // Full-scale positive offsets: a negative full-scale sample must clip low.
        add_calibration(MIX_MAX, CAL_N);
        add_uniform(32'h0);
        add_uniform(32'h8000_0000);
        add_uniform(32'h7fff_ffff);
        // Full-scale negative offsets: a positive full-scale sample must clip high.
        add_calibration(MIX_MIN, CAL_N);
        add_uniform(32'h8000_0000);
        add_uniform(32'h7fff_ffff);
        add_uniform(32'h8000_0000);
        // Aborts part way and where the completing beat would come keep the old offsets.
        add_calibration(MIX_RANDOM, 30);
        add_cmd(REQ_ABORT);
        add_uniform(32'h0);
        add_calibration(MIX_RANDOM, CAL_N);
        add_cmd(REQ_ABORT);
        add_uniform(32'h7fff_ffff);
        // A second start part way through restarts the sums.
        add_calibration(MIX_RANDOM, 20);
        add_calibration(MIX_NEAR, CAL_N);
        add_rand_sample();
        add_uniform(32'h0);
        add_rand_sample();

        // Random traffic until the total number of beats is reached.
        while (queued < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                add_calibration(cal_mix_t'($urandom_range(0, 3)), CAL_N);
                add_rand_sample();
                n = $urandom_range(3, 20);
                repeat (n) add_rand_sample();
            end
            else if (pick < 55)
            begin
                add_calibration(cal_mix_t'($urandom_range(0, 3)), $urandom_range(0, CAL_N));
                if ($urandom_range(0, 1) == 0)
                    add_cmd(REQ_ABORT);
            end
            else if (pick < 65)
                add_cmd(2'($urandom_range(1, 3)));
            else
            begin
                n = $urandom_range(1, 15);
                repeat (n) add_rand_sample();
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || sample_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("six_axis_offset_tare_tb passed");
        else
            $display("six_axis_offset_tare_tb failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for the result stream to drain");
        $display("six_axis_offset_tare_tb failed");
        $finish;
    end

endmodule
